// ----- rtl/bcn_pkg.sv -----
// Shared types, format codes and arithmetic helpers for the BCn block decoder.
package bcn_pkg;

  localparam int TexelsPerBlock = 16;
  localparam int TexelIdxWidth  = 4;
  localparam int FmtWidth       = 3;

  localparam logic [FmtWidth-1:0] FMT_BC1 = 3'd0;
  localparam logic [FmtWidth-1:0] FMT_BC2 = 3'd1;
  localparam logic [FmtWidth-1:0] FMT_BC3 = 3'd2;
  localparam logic [FmtWidth-1:0] FMT_BC4 = 3'd3;
  localparam logic [FmtWidth-1:0] FMT_BC5 = 3'd4;

  typedef enum logic [2:0] {
    DIV_1,
    DIV_2,
    DIV_3,
    DIV_5,
    DIV_7
  } div_t;

  // Interpolation numerator and the constant it is to be divided by.
  typedef struct packed {
    logic [10:0] num;
    div_t        div;
  } num_t;

  function automatic logic [7:0] expand5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] expand6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  // Palette entry of a colour block for one channel, before division.
  function automatic num_t colour_num(input logic [7:0] p, input logic [7:0] q,
                                      input logic [1:0] sel, input logic four);
    num_t r;
    r.num = 11'd0;
    r.div = DIV_1;
    case (sel)
      2'd0: r.num = {3'b000, p};
      2'd1: r.num = {3'b000, q};
      2'd2: begin
        if (four) begin
          r.num = {2'b00, p, 1'b0} + {3'b000, q};
          r.div = DIV_3;
        end else begin
          r.num = {3'b000, p} + {3'b000, q};
          r.div = DIV_2;
        end
      end
      default: begin
        if (four) begin
          r.num = {3'b000, p} + {2'b00, q, 1'b0};
          r.div = DIV_3;
        end
      end
    endcase
    return r;
  endfunction

  // Level of an 8-level scalar block, before division.
  function automatic num_t scalar_num(input logic [7:0] a0, input logic [7:0] a1,
                                      input logic [2:0] sel);
    num_t       r;
    logic [2:0] k;
    logic [2:0] w0;
    k     = sel - 3'd1;
    r.num = 11'd0;
    r.div = DIV_1;
    if (sel == 3'd0) begin
      r.num = {3'b000, a0};
    end else if (sel == 3'd1) begin
      r.num = {3'b000, a1};
    end else if (a0 > a1) begin
      w0    = 3'd7 - k;
      r.num = 11'(a0) * 11'(w0) + 11'(a1) * 11'(k);
      r.div = DIV_7;
    end else if (sel == 3'd6) begin
      r.num = 11'd0;
    end else if (sel == 3'd7) begin
      r.num = 11'd255;
    end else begin
      w0    = 3'd5 - k;
      r.num = 11'(a0) * 11'(w0) + 11'(a1) * 11'(k);
      r.div = DIV_5;
    end
    return r;
  endfunction

  // Truncating division by a small constant through a scaled reciprocal.
  // The scale factors are exact over the numerator ranges that occur here.
  function automatic logic [7:0] div_const(input num_t n);
    logic [23:0] prod;
    logic [7:0]  res;
    prod = 24'd0;
    res  = 8'd0;
    unique case (n.div)
      DIV_1: res = n.num[7:0];
      DIV_2: res = n.num[8:1];
      DIV_3: begin
        prod = 24'(n.num) * 24'd683;
        res  = prod[18:11];
      end
      DIV_5: begin
        prod = 24'(n.num) * 24'd1639;
        res  = prod[20:13];
      end
      DIV_7: begin
        prod = 24'(n.num) * 24'd2341;
        res  = prod[21:14];
      end
      default: res = 8'd0;
    endcase
    return res;
  endfunction

endpackage

// ----- rtl/bcn_texture_block_decoder.sv -----
// BC1 to BC5 texture block decoder: one compressed block in, sixteen RGBA8 texels out.
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------------
//  in      | in_valid/in_stall  | in_block_low, in_block_high
//  out     | out_valid/out_stall| out_red/green/blue/alpha, out_texel_index, last
//  cfg     | cfg_wr_en          | cfg_wr_data (block format)
//
// A block yields sixteen texels, one per cycle unless out_stall holds the pipeline;
// a new block is taken as the single-texel issue counter issues the last texel.
// Each texel passes the issue stage, stage 1, stage 2 and the output stage in turn.
// Reset is synchronous and clears only valid bits, the counter and the format.
// out_stall freezes the texel pipeline; the held block waits in the issue stage.
module bcn_texture_block_decoder
  import bcn_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [FmtWidth-1:0]      cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [63:0]              in_block_low,
  input  logic [63:0]              in_block_high,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [7:0]               out_red,
  output logic [7:0]               out_green,
  output logic [7:0]               out_blue,
  output logic [7:0]               out_alpha,
  output logic [TexelIdxWidth-1:0] out_texel_index,
  output logic                     out_last_texel
);

  logic [FmtWidth-1:0] fmt_r;

  // Issue stage: held block and texel counter.
  logic                     blk_v_r;
  logic [63:0]              blk_lo_r;
  logic [63:0]              blk_hi_r;
  logic [FmtWidth-1:0]      blk_fmt_r;
  logic [TexelIdxWidth-1:0] cnt_r;

  // Stage 1: fields of one texel.
  logic                     s1_v_r;
  logic [FmtWidth-1:0]      s1_fmt_r;
  logic [TexelIdxWidth-1:0] s1_tidx_r;
  logic [15:0]              s1_e0_r;
  logic [15:0]              s1_e1_r;
  logic [1:0]               s1_csel_r;
  logic [7:0]               s1_a0_r;
  logic [7:0]               s1_a1_r;
  logic [2:0]               s1_asel_r;
  logic [7:0]               s1_b0_r;
  logic [7:0]               s1_b1_r;
  logic [2:0]               s1_bsel_r;
  logic [3:0]               s1_nib_r;

  // Stage 2: interpolation numerators.
  logic                     s2_v_r;
  logic [FmtWidth-1:0]      s2_fmt_r;
  logic [TexelIdxWidth-1:0] s2_tidx_r;
  logic [3:0]               s2_nib_r;
  num_t                     s2_cnum_r [3];
  logic [7:0]               s2_calpha_r;
  num_t                     s2_anum_r;
  num_t                     s2_bnum_r;

  // Output stage.
  logic                     out_v_r;
  logic [7:0]               out_red_r;
  logic [7:0]               out_green_r;
  logic [7:0]               out_blue_r;
  logic [7:0]               out_alpha_r;
  logic [TexelIdxWidth-1:0] out_tidx_r;

  logic out_adv;
  logic s2_adv;
  logic s1_adv;
  logic issue;
  logic last_issue;
  logic in_acc;

  assign out_adv    = !out_v_r || !out_stall;
  assign s2_adv     = !s2_v_r || out_adv;
  assign s1_adv     = !s1_v_r || s2_adv;
  assign issue      = blk_v_r && s1_adv;
  assign last_issue = issue && (cnt_r == TexelIdxWidth'(TexelsPerBlock - 1));
  assign in_stall   = blk_v_r && !last_issue;
  assign in_acc     = in_valid && !in_stall;

  // Stage 1 field extraction.
  logic [63:0] col_word;
  assign col_word = (blk_fmt_r == FMT_BC1) ? blk_lo_r : blk_hi_r;

  // Stage 2 numerators.
  logic [7:0] p_ch [3];
  logic [7:0] q_ch [3];
  logic       four;
  num_t       cnum_nxt [3];
  num_t       anum_nxt;
  num_t       bnum_nxt;
  logic [7:0] calpha_nxt;

  always_comb begin
    p_ch[0]    = expand5(s1_e0_r[15:11]);
    p_ch[1]    = expand6(s1_e0_r[10:5]);
    p_ch[2]    = expand5(s1_e0_r[4:0]);
    q_ch[0]    = expand5(s1_e1_r[15:11]);
    q_ch[1]    = expand6(s1_e1_r[10:5]);
    q_ch[2]    = expand5(s1_e1_r[4:0]);
    four       = (s1_fmt_r != FMT_BC1) || (s1_e0_r > s1_e1_r);
    for (int ch = 0; ch < 3; ch++) begin
      cnum_nxt[ch] = colour_num(p_ch[ch], q_ch[ch], s1_csel_r, four);
    end
    // The transparent entry of a three-colour palette is black with alpha zero.
    calpha_nxt = (!four && s1_csel_r == 2'd3) ? 8'd0 : 8'd255;
    anum_nxt   = scalar_num(s1_a0_r, s1_a1_r, s1_asel_r);
    bnum_nxt   = scalar_num(s1_b0_r, s1_b1_r, s1_bsel_r);
  end

  // Output stage: divide and assemble the texel.
  logic [7:0] cval [3];
  logic [7:0] aval;
  logic [7:0] bval;
  logic [7:0] red_nxt;
  logic [7:0] green_nxt;
  logic [7:0] blue_nxt;
  logic [7:0] alpha_nxt;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      cval[ch] = div_const(s2_cnum_r[ch]);
    end
    aval = div_const(s2_anum_r);
    bval = div_const(s2_bnum_r);
    red_nxt   = 8'd0;
    green_nxt = 8'd0;
    blue_nxt  = 8'd0;
    alpha_nxt = 8'd0;
    unique case (s2_fmt_r)
      FMT_BC1: begin
        red_nxt   = cval[0];
        green_nxt = cval[1];
        blue_nxt  = cval[2];
        alpha_nxt = s2_calpha_r;
      end
      FMT_BC2: begin
        red_nxt   = cval[0];
        green_nxt = cval[1];
        blue_nxt  = cval[2];
        alpha_nxt = {s2_nib_r, s2_nib_r};
      end
      FMT_BC3: begin
        red_nxt   = cval[0];
        green_nxt = cval[1];
        blue_nxt  = cval[2];
        alpha_nxt = aval;
      end
      FMT_BC4: begin
        red_nxt   = aval;
        green_nxt = aval;
        blue_nxt  = aval;
        alpha_nxt = 8'd255;
      end
      FMT_BC5: begin
        red_nxt   = aval;
        green_nxt = bval;
        alpha_nxt = 8'd255;
      end
      default: begin
        red_nxt = 8'd0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= FMT_BC1;
      blk_v_r <= 1'b0;
      cnt_r   <= '0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        fmt_r <= cfg_wr_data;
      end
      if (in_acc) begin
        blk_v_r <= 1'b1;
        cnt_r   <= '0;
      end else if (issue) begin
        cnt_r <= cnt_r + 1'b1;
        if (last_issue) begin
          blk_v_r <= 1'b0;
        end
      end
      if (s1_adv) begin
        s1_v_r <= issue;
      end
      if (s2_adv) begin
        s2_v_r <= s1_v_r;
      end
      if (out_adv) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      blk_lo_r  <= in_block_low;
      blk_hi_r  <= in_block_high;
      blk_fmt_r <= fmt_r;
    end
    if (s1_adv) begin
      s1_fmt_r  <= blk_fmt_r;
      s1_tidx_r <= cnt_r;
      s1_e0_r   <= col_word[15:0];
      s1_e1_r   <= col_word[31:16];
      s1_csel_r <= col_word[32 + 2 * cnt_r +: 2];
      s1_a0_r   <= blk_lo_r[7:0];
      s1_a1_r   <= blk_lo_r[15:8];
      s1_asel_r <= blk_lo_r[16 + 3 * cnt_r +: 3];
      s1_b0_r   <= blk_hi_r[7:0];
      s1_b1_r   <= blk_hi_r[15:8];
      s1_bsel_r <= blk_hi_r[16 + 3 * cnt_r +: 3];
      s1_nib_r  <= blk_lo_r[4 * cnt_r +: 4];
    end
    if (s2_adv) begin
      s2_fmt_r    <= s1_fmt_r;
      s2_tidx_r   <= s1_tidx_r;
      s2_nib_r    <= s1_nib_r;
      s2_cnum_r   <= cnum_nxt;
      s2_calpha_r <= calpha_nxt;
      s2_anum_r   <= anum_nxt;
      s2_bnum_r   <= bnum_nxt;
    end
    if (out_adv) begin
      out_red_r   <= red_nxt;
      out_green_r <= green_nxt;
      out_blue_r  <= blue_nxt;
      out_alpha_r <= alpha_nxt;
      out_tidx_r  <= s2_tidx_r;
    end
  end

  assign out_valid       = out_v_r;
  assign out_red         = out_red_r;
  assign out_green       = out_green_r;
  assign out_blue        = out_blue_r;
  assign out_alpha       = out_alpha_r;
  assign out_texel_index = out_tidx_r;
  assign out_last_texel  = (out_tidx_r == TexelIdxWidth'(TexelsPerBlock - 1));

endmodule

// ----- test/tb_bcn_texture_block_decoder.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the BC1 to BC5 texture block decoder.
module tb_bcn_texture_block_decoder;
  import bcn_pkg::*;

  // Highest format code; the codes above BC5 must give all-zero texels.
  localparam logic [FmtWidth-1:0] FMT_RSVD7 = 3'd7;

  localparam int CYCLE_LIMIT      = 400000;
  localparam int DRAIN_CYCLES     = 12;
  localparam int NUM_PHASES       = 14;
  localparam int BLOCKS_PER_PHASE = 28;
  localparam int MAX_REPORTS      = 100;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
  } block_t;

  typedef struct packed {
    logic [7:0]               red;
    logic [7:0]               green;
    logic [7:0]               blue;
    logic [7:0]               alpha;
    logic [TexelIdxWidth-1:0] index;
    logic                     last;
  } texel_t;

  logic                     clk           = 1'b0;
  logic                     rst_n         = 1'b0;
  logic                     cfg_wr_en     = 1'b0;
  logic [FmtWidth-1:0]      cfg_wr_data   = '0;
  logic                     in_valid      = 1'b0;
  logic                     in_stall;
  logic [63:0]              in_block_low  = '0;
  logic [63:0]              in_block_high = '0;
  logic                     out_valid;
  logic                     out_stall     = 1'b0;
  logic [7:0]               out_red;
  logic [7:0]               out_green;
  logic [7:0]               out_blue;
  logic [7:0]               out_alpha;
  logic [TexelIdxWidth-1:0] out_texel_index;
  logic                     out_last_texel;

  block_t              blocks_to_send[$];
  texel_t              expected_texels[$];
  block_t              next_blk;
  logic [FmtWidth-1:0] format_copy = FMT_BC1;
  bit                  in_calm     = 1'b0;
  bit                  out_calm    = 1'b0;
  int                  in_gap      = 0;
  int                  out_hold    = 0;
  int                  fail_count  = 0;
  int                  texels_seen = 0;
  int                  cycle_count = 0;

  bcn_texture_block_decoder u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_block_low    (in_block_low),
    .in_block_high   (in_block_high),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_alpha       (out_alpha),
    .out_texel_index (out_texel_index),
    .out_last_texel  (out_last_texel)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Expands an RGB565 endpoint to three 8-bit channels, packed as {r, g, b}.
  function automatic logic [23:0] expand_565(input logic [15:0] c);
    int r5;
    int g6;
    int b5;
    r5 = c[15:11];
    g6 = c[10:5];
    b5 = c[4:0];
    return {8'((r5 << 3) | (r5 >> 2)), 8'((g6 << 2) | (g6 >> 4)), 8'((b5 << 3) | (b5 >> 2))};
  endfunction

  // One texel of a colour half-block, packed as {r, g, b, a}.
  function automatic logic [31:0] colour_texel(input logic [63:0] w, input bit force_four,
                                               input int t);
    logic [23:0] pe;
    logic [23:0] qe;
    logic [1:0]  sel;
    logic [31:0] rgba;
    bit          four;
    int          ch;
    int          p;
    int          q;
    int          v;
    pe   = expand_565(w[15:0]);
    qe   = expand_565(w[31:16]);
    sel  = w[32 + 2 * t +: 2];
    four = force_four || (w[15:0] > w[31:16]);
    rgba = '0;
    for (ch = 0; ch < 3; ch++) begin
      p = pe[8 * (2 - ch) +: 8];
      q = qe[8 * (2 - ch) +: 8];
      case (sel)
        2'd0: v = p;
        2'd1: v = q;
        2'd2: v = four ? (2 * p + q) / 3 : (p + q) / 2;
        default: v = four ? (p + 2 * q) / 3 : 0;
      endcase
      rgba[8 * (3 - ch) +: 8] = 8'(v);
    end
    // Index three of a three-colour palette is transparent black.
    rgba[7:0] = (sel == 2'd3 && !four) ? 8'd0 : 8'd255;
    return rgba;
  endfunction

  // One value of an 8-level scalar half-block.
  function automatic logic [7:0] scalar_texel(input logic [63:0] w, input int t);
    logic [2:0] sel;
    int         a0;
    int         a1;
    int         k;
    int         v;
    a0  = w[7:0];
    a1  = w[15:8];
    sel = w[16 + 3 * t +: 3];
    k   = int'(sel) - 1;
    if (sel == 3'd0) v = a0;
    else if (sel == 3'd1) v = a1;
    else if (a0 > a1) v = ((7 - k) * a0 + k * a1) / 7;
    else if (sel == 3'd6) v = 0;
    else if (sel == 3'd7) v = 255;
    else v = ((5 - k) * a0 + k * a1) / 5;
    return 8'(v);
  endfunction

  // Queues the sixteen texels that an accepted block must decode to.
  task automatic predict_block(input block_t blk);
    texel_t      tx;
    logic [31:0] rgba;
    logic [7:0]  lum;
    int          t;
    for (t = 0; t < TexelsPerBlock; t++) begin
      case (format_copy)
        FMT_BC1: rgba = colour_texel(blk.lo, 1'b0, t);
        FMT_BC2: begin
          rgba      = colour_texel(blk.hi, 1'b1, t);
          rgba[7:0] = {2{blk.lo[4 * t +: 4]}};
        end
        FMT_BC3: begin
          rgba      = colour_texel(blk.hi, 1'b1, t);
          rgba[7:0] = scalar_texel(blk.lo, t);
        end
        FMT_BC4: begin
          lum  = scalar_texel(blk.lo, t);
          rgba = {lum, lum, lum, 8'd255};
        end
        FMT_BC5: rgba = {scalar_texel(blk.lo, t), scalar_texel(blk.hi, t), 8'd0, 8'd255};
        default: rgba = '0;
      endcase
      tx.red   = rgba[31:24];
      tx.green = rgba[23:16];
      tx.blue  = rgba[15:8];
      tx.alpha = rgba[7:0];
      tx.index = TexelIdxWidth'(t);
      tx.last  = (t == TexelsPerBlock - 1);
      expected_texels.push_back(tx);
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("texel %0d: %s is %0h, expected %0h", texels_seen, what, got, want);
  endtask

  task automatic check_texel();
    texel_t want;
    if (expected_texels.size() == 0) begin
      report_mismatch("index of a texel with none outstanding", out_texel_index, 0);
    end else begin
      want = expected_texels.pop_front();
      if (out_red !== want.red) report_mismatch("red", out_red, want.red);
      if (out_green !== want.green) report_mismatch("green", out_green, want.green);
      if (out_blue !== want.blue) report_mismatch("blue", out_blue, want.blue);
      if (out_alpha !== want.alpha) report_mismatch("alpha", out_alpha, want.alpha);
      if (out_texel_index !== want.index)
        report_mismatch("texel_index", out_texel_index, want.index);
      if (out_last_texel !== want.last)
        report_mismatch("last_texel", out_last_texel, want.last);
    end
    texels_seen++;
  endtask

  // Mostly random words, with endpoint pairs made equal or the whole word pinned
  // to an extreme now and then so that the degenerate palettes come up often.
  function automatic logic [63:0] random_word();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: begin
        w[15:8]  = w[7:0];
        w[31:16] = w[15:0];
      end
      1: w = $urandom_range(0, 1) ? '1 : '0;
      default: ;
    endcase
    return w;
  endfunction

  task automatic wait_idle();
    while (blocks_to_send.size() != 0 || in_valid || expected_texels.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_format(input logic [FmtWidth-1:0] fmt);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= fmt;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    format_copy = fmt;
  endtask

  // Block driver: a transaction's prediction is made at the edge that accepts it.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && !in_stall) predict_block({in_block_low, in_block_high});
      if (!(in_valid && in_stall)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (blocks_to_send.size() > 0) begin
          next_blk = blocks_to_send.pop_front();
          in_valid      <= 1'b1;
          in_block_low  <= next_blk.lo;
          in_block_high <= next_blk.hi;
          in_gap = in_calm ? 0 : $urandom_range(0, 3);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Texel monitor with a random stall drawn after every accepted texel unless out_calm is set.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        check_texel();
        out_hold = out_calm ? 0 : $urandom_range(0, 3);
      end
      if (out_hold > 0) begin
        out_stall <= 1'b1;
        out_hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("bcn_texture_block_decoder test failed");
      $finish;
    end
  end

  initial begin
    block_t              directed[5];
    logic [FmtWidth-1:0] fmt;
    int                  ph;
    int                  n;
    int                  d;
    // Zero and all-ones blocks hit equal endpoints; the others hit the four-colour
    // palette and both scalar ramps with every index value present.
    directed[0] = {64'h0, 64'h0};
    directed[1] = {64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF};
    directed[2] = {64'hE4E4_E4E4_0000_FFFF, 64'hE4E4_E4E4_0000_FFFF};
    directed[3] = {64'hFAC6_88FA_C688_00FF, 64'hFAC6_88FA_C688_00FF};
    directed[4] = {64'hFAC6_88FA_C688_FF00, 64'hFAC6_88FA_C688_FF00};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      // The first pass visits every format code in order, the rest pick at random.
      if (ph <= int'(FMT_RSVD7)) fmt = FmtWidth'(ph);
      else fmt = FmtWidth'($urandom_range(int'(FMT_BC1), int'(FMT_RSVD7)));
      wait_idle();
      write_format(fmt);
      in_calm  = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      if (ph <= int'(FMT_BC5))
        for (d = 0; d < 5; d++) blocks_to_send.push_back(directed[d]);
      for (n = 0; n < BLOCKS_PER_PHASE; n++)
        blocks_to_send.push_back(block_t'({random_word(), random_word()}));
    end
    wait_idle();
    if (fail_count == 0) begin
      $display("bcn_texture_block_decoder test passed");
    end else begin
      $display("bcn_texture_block_decoder test failed");
    end
    $finish;
  end

endmodule
